@@ rtl/bce_pkg.sv @@
`default_nettype none
package bce_pkg;

  localparam int COUNT_BITS = 48;
  localparam int FRAC_BITS  = 32;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [62:0]           VAL_MAX = '1;

  localparam logic [31:0]         QUANTILE_Z_RST = 32'd43233834;
  localparam logic [31:0]         TARGET_RST     = 32'd4294967;
  localparam logic [COUNT_BITS-1:0] MAX_RUNS_RST = COUNT_BITS'(100000000);

  localparam logic [6:0] MUL_STEPS  = 7'd64;
  localparam logic [6:0] DIV_STEPS  = 7'd96;
  localparam logic [6:0] SQRT_STEPS = 7'd64;

  typedef enum logic [1:0] {
    CFG_QUANTILE_Z       = 2'd0,
    CFG_TARGET_REL_WIDTH = 2'd1,
    CFG_MAX_RUNS         = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_MEAN,
    ST_DIV_MEAN,
    ST_MUL_MOM,
    ST_DIV_MOM,
    ST_SQUARE,
    ST_ROOT_VAR,
    ST_ROOT_ACC,
    ST_MUL_WIDTH,
    ST_DIV_WIDTH,
    ST_MUL_TARGET,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e          op;
    logic [127:0] opa;
    logic [63:0]  opb;
  } unit_cmd_t;

  typedef struct packed {
    logic               batch_bernoulli;
    logic [31:0]        batch_paths;
    logic [31:0]        batch_accepted;
    logic signed [63:0] batch_mean;
    logic [62:0]        batch_moment;
  } bce_in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] total_count;
    logic [COUNT_BITS-1:0] accepted_count;
    logic signed [63:0]    estimate;
    logic [62:0]           deviation;
    logic [62:0]           interval_width;
    logic signed [63:0]    interval_low;
    logic signed [63:0]    interval_high;
    logic                  done_res;
  } bce_out_t;

endpackage
`default_nettype wire

@@ rtl/bce_unit.sv @@
`default_nettype none
module bce_unit import bce_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire unit_cmd_t    cmd_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [127:0]      res_o
);

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [6:0]   cnt_q, cnt_d;
  op_e          op_q, op_d;
  logic [127:0] x_q, x_d;
  logic [127:0] acc_q, acc_d;
  logic [65:0]  rem_q, rem_d;
  logic [63:0]  dv_q, dv_d;

  logic [127:0] mul_sum;
  logic [64:0]  div_r, div_sub;
  logic         div_ge;
  logic [65:0]  sq_t, sq_trial, sq_sub;
  logic         sq_ge;

  always_comb begin
    mul_sum  = {acc_q[126:0], 1'b0} + (x_q[127] ? {64'b0, dv_q} : 128'b0);
    div_r    = {rem_q[63:0], x_q[127]};
    div_ge   = div_r >= {1'b0, dv_q};
    div_sub  = div_r - {1'b0, dv_q};
    sq_t     = {rem_q[63:0], x_q[127:126]};
    sq_trial = {acc_q[63:0], 2'b01};
    sq_ge    = sq_t >= sq_trial;
    sq_sub   = sq_t - sq_trial;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    x_d    = x_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      acc_d  = '0;
      rem_d  = '0;
      case (cmd_i.op)
        OP_MUL: begin
          x_d   = {cmd_i.opb, 64'b0};
          dv_d  = cmd_i.opa[63:0];
          cnt_d = MUL_STEPS;
        end
        OP_DIV: begin
          x_d   = {cmd_i.opa[95:0], 32'b0};
          dv_d  = cmd_i.opb;
          cnt_d = DIV_STEPS;
        end
        default: begin
          x_d   = cmd_i.opa;
          dv_d  = '0;
          cnt_d = SQRT_STEPS;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          acc_d = mul_sum;
          x_d   = {x_q[126:0], 1'b0};
        end
        OP_DIV: begin
          rem_d = {2'b0, div_ge ? div_sub[63:0] : div_r[63:0]};
          acc_d = {acc_q[126:0], div_ge};
          x_d   = {x_q[126:0], 1'b0};
        end
        default: begin
          rem_d = sq_ge ? sq_sub : sq_t;
          acc_d = {64'b0, acc_q[62:0], sq_ge};
          x_d   = {x_q[125:0], 2'b0};
        end
      endcase
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 7'd0) else $error("unit busy with empty step count");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("unit done while still busy");
  a_done_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("unit done without a running op");

endmodule
`default_nettype wire

@@ rtl/batch_confidence_estimator.sv @@
`default_nettype none
// Batch confidence estimator.
// Input channel: one beat per simulation batch (in_valid_i / in_stall_o /
// in_data_i). Output channel: one result beat per batch (out_valid_o /
// out_stall_i / out_data_o) carrying totals, merged mean, deviation,
// interval width and bounds, and the done flag.
// Config port: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 quantile_z, 1 target_rel_width, 2 max_runs); write only while idle.
// One shared multi-cycle unit does every multiply (64 steps), divide
// (96 steps) and square root (64 steps) under a small sequencer. A batch
// with a nonzero accepted total runs ten unit ops from accept to result;
// with a zero accepted total three ops run.
// in_stall_o stays high from accept until the result is loaded into the
// output register, so one batch is in flight at a time.
// A result waits in the output register while out_stall_i is high; the
// next batch may be accepted and computed meanwhile, and its finish step
// holds until the output register is free.
// Reset clears the running totals, mean and moment, sets the Bernoulli
// flag and loads the configuration defaults.
module batch_confidence_estimator import bce_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire bce_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output bce_out_t                   out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [COUNT_BITS-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [31:0]           z_q, tgt_q;
  logic [COUNT_BITS-1:0] max_q;
  logic [COUNT_BITS-1:0] total_q, accept_q;
  logic [63:0]           mean_q, moment_q;
  logic                  allb_q;
  logic                  issued_q;
  logic                  out_valid_q;
  bce_out_t              out_q;

  logic [31:0]           a_q;
  logic [63:0]           xmean_q;
  logic [62:0]           xmom_q;
  logic [63:0]           var_q;
  logic [47:0]           stdev_q;
  logic [39:0]           sroot_q;
  logic [62:0]           width_q;
  logic                  done_q;

  logic                  ustart, ubusy, udone;
  unit_cmd_t             ucmd;
  logic [127:0]          ures;

  logic [COUNT_BITS:0]   tot_sum, acc_sum;
  logic [COUNT_BITS-1:0] tot_new, acc_new;
  logic [63:0]           amean;
  logic                  out_free;
  logic                  compute;
  logic [64:0]           lo65, hi65;
  logic signed [63:0]    lo_b, hi_b;
  logic [62:0]           half;

  function automatic logic [63:0] mag_diff(input logic [63:0] cur, input logic [63:0] x);
    logic neg;
    neg = $signed(x) < $signed(cur);
    return neg ? cur - x : x - cur;
  endfunction

  function automatic logic [63:0] merge_upd(input logic [63:0] cur, input logic [63:0] x,
                                            input logic [63:0] q);
    logic neg;
    neg = $signed(x) < $signed(cur);
    return neg ? cur - q : cur + q;
  endfunction

  bce_unit u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ustart),
    .cmd_i   (ucmd),
    .busy_o  (ubusy),
    .done_o  (udone),
    .res_o   (ures)
  );

  // Saturating count update for the incoming beat, absolute mean and output-register free flag.
  always_comb begin
    tot_sum = {1'b0, total_q} + (COUNT_BITS+1)'(in_data_i.batch_paths);
    acc_sum = {1'b0, accept_q} + (COUNT_BITS+1)'(in_data_i.batch_accepted);
    tot_new = tot_sum[COUNT_BITS] ? CNT_MAX : tot_sum[COUNT_BITS-1:0];
    acc_new = acc_sum[COUNT_BITS] ? CNT_MAX : acc_sum[COUNT_BITS-1:0];
    amean   = mean_q[63] ? 64'(-mean_q) : mean_q;
    out_free = !out_valid_q || !out_stall_i;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = (acc_new != '0) ? ST_MUL_MEAN : ST_SQUARE;
      ST_MUL_MEAN:   if (udone) state_d = ST_DIV_MEAN;
      ST_DIV_MEAN:   if (udone) state_d = ST_MUL_MOM;
      ST_MUL_MOM:    if (udone) state_d = ST_DIV_MOM;
      ST_DIV_MOM:    if (udone) state_d = ST_SQUARE;
      ST_SQUARE:     if (udone) state_d = ST_ROOT_VAR;
      ST_ROOT_VAR:   if (udone) state_d = (accept_q != '0) ? ST_ROOT_ACC : ST_MUL_TARGET;
      ST_ROOT_ACC:   if (udone) state_d = ST_MUL_WIDTH;
      ST_MUL_WIDTH:  if (udone) state_d = ST_DIV_WIDTH;
      ST_DIV_WIDTH:  if (udone) state_d = ST_MUL_TARGET;
      ST_MUL_TARGET: if (udone) state_d = ST_FINISH;
      ST_FINISH:     if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Unit commands per state.
  always_comb begin
    compute  = (state_q != ST_IDLE) && (state_q != ST_FINISH);
    ustart   = compute && !issued_q;
    ucmd.op  = OP_MUL;
    ucmd.opa = '0;
    ucmd.opb = '0;
    case (state_q)
      ST_MUL_MEAN: begin
        ucmd.opa = 128'(mag_diff(mean_q, xmean_q));
        ucmd.opb = 64'(a_q);
      end
      ST_DIV_MEAN, ST_DIV_MOM: begin
        ucmd.op  = OP_DIV;
        ucmd.opa = ures;
        ucmd.opb = 64'(accept_q);
      end
      ST_MUL_MOM: begin
        ucmd.opa = 128'(mag_diff(moment_q, {1'b0, xmom_q}));
        ucmd.opb = 64'(a_q);
      end
      ST_SQUARE: begin
        ucmd.opa = 128'(amean);
        ucmd.opb = amean;
      end
      ST_ROOT_VAR: begin
        ucmd.op  = OP_SQRT;
        ucmd.opa = 128'(var_q) << FRAC_BITS;
      end
      ST_ROOT_ACC: begin
        ucmd.op  = OP_SQRT;
        ucmd.opa = 128'(accept_q) << 32;
      end
      ST_MUL_WIDTH: begin
        ucmd.opa = 128'({z_q, 1'b0});
        ucmd.opb = 64'(stdev_q);
      end
      ST_DIV_WIDTH: begin
        ucmd.op  = OP_DIV;
        ucmd.opa = ures;
        ucmd.opb = 64'({sroot_q, 8'b0});
      end
      ST_MUL_TARGET: begin
        ucmd.opa = 128'(amean);
        ucmd.opb = 64'(tgt_q);
      end
      default: begin
        ucmd.op = OP_MUL;
      end
    endcase
  end

  // Interval bounds: mean -/+ half width, saturated, then Bernoulli clamp.
  always_comb begin
    half = {1'b0, width_q[62:1]};
    lo65 = {mean_q[63], mean_q} - 65'(half);
    hi65 = {mean_q[63], mean_q} + 65'(half);
    lo_b = (lo65[64] != lo65[63]) ? {1'b1, 63'b0} : lo65[63:0];
    hi_b = (hi65[64] != hi65[63]) ? {1'b0, VAL_MAX} : hi65[63:0];
    if (allb_q) begin
      if (lo_b < 0) lo_b = '0;
      if (hi_b > (64'sd1 <<< FRAC_BITS)) hi_b = 64'sd1 <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      z_q         <= QUANTILE_Z_RST;
      tgt_q       <= TARGET_RST;
      max_q       <= MAX_RUNS_RST;
      total_q     <= '0;
      accept_q    <= '0;
      mean_q      <= '0;
      moment_q    <= '0;
      allb_q      <= 1'b1;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_QUANTILE_Z:       z_q   <= cfg_data_i[31:0];
          CFG_TARGET_REL_WIDTH: tgt_q <= cfg_data_i[31:0];
          CFG_MAX_RUNS:         max_q <= cfg_data_i;
          default:              ;
        endcase
      end
      if (ustart) begin
        issued_q <= 1'b1;
      end else if (udone) begin
        issued_q <= 1'b0;
      end
      // Accept: fold counts and the Bernoulli mark in right away.
      if (state_q == ST_IDLE && in_valid_i) begin
        total_q  <= tot_new;
        accept_q <= acc_new;
        allb_q   <= allb_q & in_data_i.batch_bernoulli;
      end
      if (udone && state_q == ST_DIV_MEAN) mean_q   <= merge_upd(mean_q, xmean_q, ures[63:0]);
      if (udone && state_q == ST_DIV_MOM) begin
        moment_q <= merge_upd(moment_q, {1'b0, xmom_q}, ures[63:0]);
      end
      // Drop the beat once taken, load the next one when finishing.
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      a_q     <= in_data_i.batch_accepted;
      xmean_q <= in_data_i.batch_mean;
      xmom_q  <= in_data_i.batch_moment;
    end
    if (udone) begin
      case (state_q)
        ST_SQUARE: begin
          if (ures[127:FRAC_BITS+64] != '0 || ures[FRAC_BITS+63:FRAC_BITS] >= moment_q) begin
            var_q <= '0;
          end else begin
            var_q <= moment_q - ures[FRAC_BITS+63:FRAC_BITS];
          end
        end
        ST_ROOT_VAR: begin
          stdev_q <= ures[47:0];
          if (accept_q == '0) width_q <= VAL_MAX;
        end
        ST_ROOT_ACC:  sroot_q <= ures[39:0];
        ST_DIV_WIDTH: width_q <= (ures[95:63] != '0) ? VAL_MAX : ures[62:0];
        ST_MUL_TARGET: begin
          done_q <= (mean_q != '0 && 128'({width_q, 32'b0}) <= ures) || (total_q >= max_q);
        end
        default: ;
      endcase
    end
    if (state_q == ST_FINISH && out_free) begin
      out_q.total_count    <= total_q;
      out_q.accepted_count <= accept_q;
      out_q.estimate       <= mean_q;
      out_q.deviation      <= 63'(stdev_q);
      out_q.interval_width <= width_q;
      out_q.interval_low   <= lo_b;
      out_q.interval_high  <= hi_b;
      out_q.done_res       <= done_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_start_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ustart |-> !ubusy) else $error("unit started while busy");
  a_idle_no_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_FINISH) |-> !ubusy && !issued_q)
    else $error("unit running outside a compute step");
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    udone |-> issued_q) else $error("unit result with no op issued");
  a_zero_acc_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && acc_new == '0) |=> state_q == ST_SQUARE)
    else $error("merge not skipped for zero accepted total");

endmodule
`default_nettype wire

@@ tb/sv/batch_confidence_estimator_tb.sv @@
`timescale 1ns / 100ps
module batch_confidence_estimator_tb;
  import bce_pkg::*;

  localparam int          RANDOM_ITEMS = 1200;
  localparam int          PHASES       = 5;
  // The limit covers the slowest batch, both sides' worst stalls and a margin.
  localparam longint      CYCLE_LIMIT  = 64'd8_000_000;
  localparam logic [62:0] M63          = '1;
  localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  bce_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  bce_out_t              out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [1:0]            cfg_index_i = '0;
  logic [COUNT_BITS-1:0] cfg_data_i = '0;

  batch_confidence_estimator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block: configuration and running statistics.
  logic [31:0]           z_quant;
  logic [31:0]           rel_target;
  logic [COUNT_BITS-1:0] path_cap;
  logic [COUNT_BITS-1:0] paths_sum, accepted_sum;
  logic signed [63:0]    mean_acc, moment_acc;
  bit                    every_bernoulli;

  bce_out_t pending_results[$];
  int       mismatches = 0;
  longint   cycles = 0;
  bit       calm = 1'b0;       // final stretch: no idling on either side
  bit       idle_enabled = 1'b1;

  typedef struct {
    bce_in_t  beat;
    bit       typed;
    bce_out_t result;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic logic [COUNT_BITS-1:0] add_saturating(logic [COUNT_BITS-1:0] a,
                                                           logic [31:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS+1)'(b);
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  // Floor square root, one result bit per pass.
  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      sq = 128'(t) * 128'(t);
      if (sq <= n) r = t;
    end
    return r;
  endfunction

  // Move cur toward x by weight a/tot; the step magnitude truncates.
  function automatic logic signed [63:0] weighted_step(logic signed [63:0] cur,
      logic signed [63:0] x, logic [31:0] a, logic [COUNT_BITS-1:0] tot);
    logic         neg;
    logic [63:0]  mag;
    logic [127:0] q;
    neg = x < cur;
    mag = neg ? 64'(cur) - 64'(x) : 64'(x) - 64'(cur);
    q = (128'(a) * 128'(mag)) / 128'(tot);
    return neg ? $signed(64'(cur) - q[63:0]) : $signed(64'(cur) + q[63:0]);
  endfunction

  // Fold one batch into the shadow statistics and derive its result beat.
  function automatic bce_out_t fold_batch(bce_in_t b);
    bce_out_t            r;
    logic [63:0]         amean, var_q, stdev, sroot;
    logic [127:0]        sq, num, den, q, lhs, rhs;
    logic [62:0]         width, half;
    logic signed [65:0]  lo, hi;
    every_bernoulli = every_bernoulli && b.batch_bernoulli;
    paths_sum    = add_saturating(paths_sum, b.batch_paths);
    accepted_sum = add_saturating(accepted_sum, b.batch_accepted);
    if (accepted_sum != 0) begin
      mean_acc   = weighted_step(mean_acc, b.batch_mean, b.batch_accepted, accepted_sum);
      moment_acc = weighted_step(moment_acc, $signed({1'b0, b.batch_moment}),
                                 b.batch_accepted, accepted_sum);
    end
    amean = mean_acc[63] ? 64'(-mean_acc) : 64'(mean_acc);
    sq = (128'(amean) * 128'(amean)) >> FRAC_BITS;
    // Clamp a negative variance to zero.
    var_q = (sq >= 128'(64'(moment_acc))) ? 64'd0 : 64'(moment_acc) - sq[63:0];
    stdev = floor_root(128'(var_q) << FRAC_BITS);
    if (accepted_sum == 0) begin
      width = M63;
    end else begin
      sroot = floor_root(128'(accepted_sum) << 32);
      num = 128'({z_quant, 1'b0}) * 128'(stdev);
      den = 128'(sroot) << 8;
      q = num / den;
      width = (q > 128'(M63)) ? M63 : q[62:0];
    end
    lhs = 128'(width) << 32;
    rhs = 128'(rel_target) * 128'(amean);
    r.done_res = (mean_acc != 0 && lhs <= rhs) || paths_sum >= path_cap;
    half = width >> 1;
    lo = 66'(mean_acc) - 66'(half);
    hi = 66'(mean_acc) + 66'(half);
    if (lo < -(66'sd1 <<< 63)) lo = -(66'sd1 <<< 63);
    if (hi > ((66'sd1 <<< 63) - 1)) hi = (66'sd1 <<< 63) - 1;
    if (every_bernoulli) begin
      if (lo < 0) lo = 0;
      if (hi > 66'(ONE)) hi = 66'(ONE);
    end
    r.total_count    = paths_sum;
    r.accepted_count = accepted_sum;
    r.estimate       = mean_acc;
    r.deviation      = stdev[62:0];
    r.interval_width = width;
    r.interval_low   = lo[63:0];
    r.interval_high  = hi[63:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed batches with random content, plus raw noise.
  function automatic bce_in_t make_batch(bit allow_plain);
    bce_in_t     b;
    int          kind;
    logic [63:0] m, mag;
    kind = $urandom_range(0, 9);
    b = '0;
    if (kind <= 4 || (kind == 5 && !allow_plain)) begin
      b.batch_bernoulli = 1'b1;
      b.batch_accepted  = $urandom_range(0, 4000);
      b.batch_paths     = b.batch_accepted + $urandom_range(0, 1000);
      b.batch_mean      = $signed(64'($urandom));
      b.batch_moment    = 63'(b.batch_mean);
    end else if (kind == 5) begin
      b.batch_bernoulli = 1'b0;
      b.batch_accepted  = $urandom_range(0, 100000);
      b.batch_paths     = b.batch_accepted + $urandom_range(0, 5000);
      m = rand64();
      b.batch_mean      = $signed({{28{m[35]}}, m[35:0]});
      mag = b.batch_mean[63] ? 64'(-b.batch_mean) : 64'(b.batch_mean);
      b.batch_moment    = 63'((128'(mag) * 128'(mag)) >> FRAC_BITS) + 63'($urandom);
    end else begin
      b.batch_bernoulli = allow_plain ? 1'($urandom) : 1'b1;
      b.batch_paths     = $urandom;
      b.batch_accepted  = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 50);
      b.batch_mean      = $signed(rand64());
      b.batch_moment    = 63'(rand64());
    end
    return b;
  endfunction

  task automatic send_batch(bce_in_t b, bit typed, bce_out_t typed_result);
    bce_out_t pred;
    int       gap;
    gap = (!calm && idle_enabled && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_data_i  = b;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pred = fold_batch(b);
    pending_results = {pending_results, (typed ? typed_result : pred)};
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [COUNT_BITS-1:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      CFG_QUANTILE_Z:       z_quant = v[31:0];
      CFG_TARGET_REL_WIDTH: rel_target = v[31:0];
      CFG_MAX_RUNS:         path_cap = v;
      default: ;
    endcase
  endtask

  task automatic apply_phase(int p);
    case (p)
      0: begin
        write_reg(CFG_QUANTILE_Z, COUNT_BITS'(QUANTILE_Z_RST));
        write_reg(CFG_TARGET_REL_WIDTH, COUNT_BITS'(TARGET_RST));
        write_reg(CFG_MAX_RUNS, MAX_RUNS_RST);
      end
      1: begin
        write_reg(CFG_QUANTILE_Z, '0);
        write_reg(CFG_TARGET_REL_WIDTH, COUNT_BITS'(1));
        write_reg(CFG_MAX_RUNS, COUNT_BITS'(1));
      end
      2: begin
        write_reg(CFG_QUANTILE_Z, COUNT_BITS'(32'hFFFF_FFFF));
        write_reg(CFG_TARGET_REL_WIDTH, COUNT_BITS'(32'hFFFF_FFFF));
        write_reg(CFG_MAX_RUNS, CNT_MAX);
      end
      3: begin
        // A zero path limit means every result reports done.
        write_reg(CFG_QUANTILE_Z, COUNT_BITS'($urandom));
        write_reg(CFG_TARGET_REL_WIDTH, COUNT_BITS'($urandom));
        write_reg(CFG_MAX_RUNS, '0);
      end
      default: begin
        write_reg(CFG_QUANTILE_Z, COUNT_BITS'(QUANTILE_Z_RST + $urandom_range(0, 1 << 24)));
        write_reg(CFG_TARGET_REL_WIDTH, COUNT_BITS'($urandom_range(1, 1 << 28)));
        write_reg(CFG_MAX_RUNS, COUNT_BITS'(rand64()));
      end
    endcase
  endtask

  task automatic add_row(bit bern, logic [31:0] paths, logic [31:0] acc,
                         logic signed [63:0] m, logic [62:0] mom);
    stim_row_t row;
    row.beat   = '{bern, paths, acc, m, mom};
    row.typed  = 1'b0;
    row.result = '0;
    directed_rows = {directed_rows, row};
  endtask

  // Directed rows stay Bernoulli-marked: one plain batch drops the clamp for good.
  task automatic build_directed();
    stim_row_t row;
    // Empty batch right after reset: no accepted paths, widest interval,
    // bounds clamped to 0..1, mean zero so never done.
    row.beat   = '0;
    row.beat.batch_bernoulli = 1'b1;
    row.typed  = 1'b1;
    row.result = '{'0, '0, '0, '0, M63, '0, ONE, 1'b0};
    directed_rows = {directed_rows, row};
    add_row(1'b1, 32'd100, 32'd100, ONE >>> 1, 63'(ONE >>> 1));
    add_row(1'b1, '1, '0, 64'sh7FFF_FFFF_FFFF_FFFF, M63);
    add_row(1'b1, '1, '1, 64'sh8000_0000_0000_0000, '0);
    add_row(1'b1, 32'd1, 32'd1, 64'sh7FFF_FFFF_FFFF_FFFF, M63);
    add_row(1'b1, 32'd10, 32'd10, '0, '0);
    add_row(1'b1, 32'd1000, 32'd1000, ONE, 63'(ONE));
    add_row(1'b1, 32'd5, 32'd5, -ONE, 63'(ONE));
    add_row(1'b1, 32'd0, 32'd7, 64'sh0000_0000_4000_0000, 63'h3FFF_FFFF_FFFF_FFFF);
    add_row(1'b1, 32'd40, 32'd0, '0, '0);
  endtask

  // Receiver side: random stall bursts, with quiet stretches.
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (calm || !idle_enabled) begin
      out_stall_i = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i = 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left  = $urandom_range(0, 12);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Check each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    bce_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no batch outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("total_count", 64'(want.total_count), 64'(out_data_o.total_count));
        compare_field("accepted_count", 64'(want.accepted_count),
                      64'(out_data_o.accepted_count));
        compare_field("estimate", want.estimate, out_data_o.estimate);
        compare_field("deviation", 64'(want.deviation), 64'(out_data_o.deviation));
        compare_field("interval_width", 64'(want.interval_width),
                      64'(out_data_o.interval_width));
        compare_field("interval_low", want.interval_low, out_data_o.interval_low);
        compare_field("interval_high", want.interval_high, out_data_o.interval_high);
        compare_field("done_res", 64'(want.done_res), 64'(out_data_o.done_res));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("batch_confidence_estimator test failed");
      $finish;
    end
  end

  initial begin
    int per_phase;
    z_quant         = QUANTILE_Z_RST;
    rel_target      = TARGET_RST;
    path_cap        = MAX_RUNS_RST;
    paths_sum       = '0;
    accepted_sum    = '0;
    mean_acc        = '0;
    moment_acc      = '0;
    every_bernoulli = 1'b1;
    per_phase       = RANDOM_ITEMS / PHASES;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    build_directed();
    foreach (directed_rows[i])
      send_batch(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      apply_phase(p);
      for (int k = 0; k < per_phase; k++) begin
        // Toggle idling now and then so quiet stretches appear too.
        if ($urandom_range(0, 39) == 0) idle_enabled = !idle_enabled;
        calm = (p == PHASES - 1) && (k > per_phase / 2);
        // Keep the Bernoulli clamp alive through the first phases.
        send_batch(make_batch(p >= 2), 1'b0, '0);
      end
      wait_drained();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("batch_confidence_estimator test passed");
    end else begin
      $display("batch_confidence_estimator test failed");
    end
    $finish;
  end

endmodule
